/* hdl/gsmc_pkg.sv */
// ----------------------------------------------------------------------------
// gsmc_pkg : grid square mesh code shared definitions
// Field widths, arcsecond bounds of the coded area, reciprocal constants for
// the digit division, and width helpers for the parameterized pipeline.
// ----------------------------------------------------------------------------
package gsmc_pkg;

  // Parameter defaults
  localparam int MAX_LEVEL_DEF = 10;
  localparam int FRAC_BITS_DEF = 10;

  // Fixed port widths
  localparam int LAT_W   = 29;
  localparam int LON_W   = 30;
  localparam int LEVEL_W = 4;
  localparam int QD_W    = 14;

  // Level handling
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd3;
  localparam int MIN_LEVEL         = 3;
  localparam int QUARTER_PER_STAGE = 4;

  // Coded area in whole arcseconds: first lat code 10..99, lon degrees 110..179
  localparam logic [LAT_W-1:0] LAT_SEC_LO = 29'd24000;
  localparam logic [LAT_W-1:0] LAT_SEC_HI = 29'd240000;
  localparam logic [LON_W-1:0] LON_SEC_LO = 30'd396000;
  localparam logic [LON_W-1:0] LON_SEC_HI = 30'd648000;

  // Offset inside the coded area (below 252000 s)
  localparam int OFS_W = 18;

  // Third mesh cell size in arcseconds, and remainder widths
  localparam int LAT_CELL_SEC = 30;
  localparam int LON_CELL_SEC = 45;
  localparam int LAT_REM_W    = 5;
  localparam int LON_REM_W    = 6;

  // First lat/lon code offset
  localparam logic [6:0] FIRST_OFS = 7'd10;

  // Quotient widths: first, second, third level counts from the area origin
  localparam int Q1_W = 7;
  localparam int Q2_W = 10;
  localparam int Q3_W = 13;

  // Reciprocals, rounded up; exact for offsets below 2^18
  localparam int RCP_SH = 32;
  localparam int RCP_W  = 28;
  localparam logic [RCP_W-1:0] RCP_2400 =
    RCP_W'(((64'd1 << RCP_SH) + 64'd2399) / 64'd2400);
  localparam logic [RCP_W-1:0] RCP_300 =
    RCP_W'(((64'd1 << RCP_SH) + 64'd299) / 64'd300);
  localparam logic [RCP_W-1:0] RCP_30 =
    RCP_W'(((64'd1 << RCP_SH) + 64'd29) / 64'd30);
  localparam logic [RCP_W-1:0] RCP_3600 =
    RCP_W'(((64'd1 << RCP_SH) + 64'd3599) / 64'd3600);
  localparam logic [RCP_W-1:0] RCP_450 =
    RCP_W'(((64'd1 << RCP_SH) + 64'd449) / 64'd450);
  localparam logic [RCP_W-1:0] RCP_45 =
    RCP_W'(((64'd1 << RCP_SH) + 64'd44) / 64'd45);

  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
  } point_t;

  typedef struct packed {
    logic [OFS_W-1:0] lat_ofs;
    logic [OFS_W-1:0] lon_ofs;
    logic [Q1_W-1:0]  lat_q1;
    logic [Q2_W-1:0]  lat_q2;
    logic [Q3_W-1:0]  lat_q3;
    logic [Q1_W-1:0]  lon_q1;
    logic [Q2_W-1:0]  lon_q2;
    logic [Q3_W-1:0]  lon_q3;
  } quot_t;

  typedef struct packed {
    logic [6:0] first_lat;
    logic [6:0] first_lon;
    logic [2:0] second_lat;
    logic [2:0] second_lon;
    logic [3:0] third_lat;
    logic [3:0] third_lon;
  } mesh_digits_t;

  // Bits for the quarter count k = level - 3, 0 .. max_level - 3
  function automatic int level_k_w(input int max_level);
    return $clog2(max_level - MIN_LEVEL + 1);
  endfunction

  function automatic int quarter_stages(input int max_level);
    return (max_level - MIN_LEVEL + QUARTER_PER_STAGE - 1) / QUARTER_PER_STAGE;
  endfunction

  // Internal quarter digit vector: covers every stage slot and the port
  function automatic int qd_int_w(input int max_level);
    int n;
    n = 2 * QUARTER_PER_STAGE * quarter_stages(max_level);
    return (n > QD_W) ? n : QD_W;
  endfunction

  function automatic int rlat_w(input int frac_bits);
    return LAT_REM_W + frac_bits;
  endfunction

  function automatic int rlon_w(input int frac_bits);
    return LON_REM_W + frac_bits;
  endfunction

endpackage

/* hdl/gsmc_front.sv */
// ----------------------------------------------------------------------------
// gsmc_front : input register and first division stage
// Captures the point and the saturated level, checks the coded area, and
// forms all six digit quotients by reciprocal multiplication.
// ----------------------------------------------------------------------------
module gsmc_front
  import gsmc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [LEVEL_W-1:0]             level,
  input  point_t                         in_pt,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  output logic [level_k_w(MAX_LEVEL)-1:0] out_k,
  output point_t                         out_pt,
  output quot_t                          out_q
);

  localparam int K_W   = level_k_w(MAX_LEVEL);
  localparam int LVL_W = LEVEL_W + 1;
  localparam int P_W   = OFS_W + RCP_W;

  // Stage A: input register
  logic           a_valid;
  logic           a_stall;
  logic           a_lvl_ok;
  logic [K_W-1:0] a_k;
  point_t         a_pt;
  logic           b_stall;

  logic [LVL_W-1:0] lvl_sat;
  logic             lvl_ok;
  logic [K_W-1:0]   k_sel;

  // Saturate the level and derive the quarter count
  always_comb begin
    if ({1'b0, level} > LVL_W'(MAX_LEVEL)) begin
      lvl_sat = LVL_W'(MAX_LEVEL);
    end else begin
      lvl_sat = {1'b0, level};
    end
    lvl_ok = (lvl_sat >= LVL_W'(MIN_LEVEL));
    k_sel  = lvl_ok ? K_W'(lvl_sat - LVL_W'(MIN_LEVEL)) : '0;
  end

  assign b_stall  = out_valid && out_stall;
  assign a_stall  = a_valid && b_stall;
  assign in_stall = a_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !a_stall) begin
      a_lvl_ok <= lvl_ok;
      a_k      <= k_sel;
      a_pt     <= in_pt;
    end
  end

  // Area check and reciprocal quotients
  logic [LAT_W-1:0] lat_sec;
  logic [LON_W-1:0] lon_sec;
  logic             in_area;
  logic [OFS_W-1:0] lat_ofs;
  logic [OFS_W-1:0] lon_ofs;
  logic [P_W-1:0]   p_lat1, p_lat2, p_lat3;
  logic [P_W-1:0]   p_lon1, p_lon2, p_lon3;
  quot_t            q_next;

  always_comb begin
    lat_sec = a_pt.lat >> FRAC_BITS;
    lon_sec = a_pt.lon >> FRAC_BITS;
    in_area = (lat_sec >= LAT_SEC_LO) && (lat_sec < LAT_SEC_HI) &&
              (lon_sec >= LON_SEC_LO) && (lon_sec < LON_SEC_HI);
    lat_ofs = OFS_W'(lat_sec - LAT_SEC_LO);
    lon_ofs = OFS_W'(lon_sec - LON_SEC_LO);

    p_lat1 = P_W'(lat_ofs) * P_W'(RCP_2400);
    p_lat2 = P_W'(lat_ofs) * P_W'(RCP_300);
    p_lat3 = P_W'(lat_ofs) * P_W'(RCP_30);
    p_lon1 = P_W'(lon_ofs) * P_W'(RCP_3600);
    p_lon2 = P_W'(lon_ofs) * P_W'(RCP_450);
    p_lon3 = P_W'(lon_ofs) * P_W'(RCP_45);

    q_next.lat_ofs = lat_ofs;
    q_next.lon_ofs = lon_ofs;
    q_next.lat_q1  = p_lat1[RCP_SH +: Q1_W];
    q_next.lat_q2  = p_lat2[RCP_SH +: Q2_W];
    q_next.lat_q3  = p_lat3[RCP_SH +: Q3_W];
    q_next.lon_q1  = p_lon1[RCP_SH +: Q1_W];
    q_next.lon_q2  = p_lon2[RCP_SH +: Q2_W];
    q_next.lon_q3  = p_lon3[RCP_SH +: Q3_W];
  end

  // Stage B register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!b_stall) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && !b_stall) begin
      out_ok <= a_lvl_ok && in_area;
      out_k  <= a_k;
      out_pt <= a_pt;
      out_q  <= q_next;
    end
  end

endmodule

/* hdl/gsmc_digits.sv */
// ----------------------------------------------------------------------------
// gsmc_digits : mesh digit stage
// Turns the nested quotients into the first, second and third level digits
// and forms the fixed-point remainders inside the third mesh cell.
// ----------------------------------------------------------------------------
module gsmc_digits
  import gsmc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_ok,
  input  logic [level_k_w(MAX_LEVEL)-1:0] in_k,
  input  point_t                         in_pt,
  input  quot_t                          in_q,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  output logic [level_k_w(MAX_LEVEL)-1:0] out_k,
  output point_t                         out_pt,
  output mesh_digits_t                   out_dg,
  output logic [rlat_w(FRAC_BITS)-1:0]   out_rlat,
  output logic [rlon_w(FRAC_BITS)-1:0]   out_rlon
);

  localparam int RL_W = rlat_w(FRAC_BITS);
  localparam int RN_W = rlon_w(FRAC_BITS);
  localparam logic [LAT_W-1:0] LAT_FRAC_MASK = LAT_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [LON_W-1:0] LON_FRAC_MASK = LON_W'((64'd1 << FRAC_BITS) - 64'd1);

  mesh_digits_t         dg;
  logic [LAT_REM_W-1:0] lat_r;
  logic [LON_REM_W-1:0] lon_r;
  logic [RL_W-1:0]      rlat;
  logic [RN_W-1:0]      rlon;

  // Nested floors: each level is the finer count minus the coarser one scaled
  always_comb begin
    dg.first_lat  = in_q.lat_q1 + FIRST_OFS;
    dg.first_lon  = in_q.lon_q1 + FIRST_OFS;
    dg.second_lat = 3'(in_q.lat_q2 - {in_q.lat_q1, 3'b000});
    dg.second_lon = 3'(in_q.lon_q2 - {in_q.lon_q1, 3'b000});
    dg.third_lat  = 4'(in_q.lat_q3 - Q3_W'(in_q.lat_q2) * Q3_W'(10));
    dg.third_lon  = 4'(in_q.lon_q3 - Q3_W'(in_q.lon_q2) * Q3_W'(10));

    // Whole arcseconds left inside the third mesh, then add the fraction
    lat_r = LAT_REM_W'(in_q.lat_ofs - OFS_W'(in_q.lat_q3) * OFS_W'(LAT_CELL_SEC));
    lon_r = LON_REM_W'(in_q.lon_ofs - OFS_W'(in_q.lon_q3) * OFS_W'(LON_CELL_SEC));
    rlat  = (RL_W'(lat_r) << FRAC_BITS) | RL_W'(in_pt.lat & LAT_FRAC_MASK);
    rlon  = (RN_W'(lon_r) << FRAC_BITS) | RN_W'(in_pt.lon & LON_FRAC_MASK);
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_ok   <= in_ok;
      out_k    <= in_k;
      out_pt   <= in_pt;
      out_dg   <= dg;
      out_rlat <= rlat;
      out_rlon <= rlon;
    end
  end

endmodule

/* hdl/gsmc_quarter.sv */
// ----------------------------------------------------------------------------
// gsmc_quarter : quarter digit stage
// Resolves up to four quarter levels per stage: the remainder is doubled and
// compared with the third mesh cell size, which halves the cell each level.
// ----------------------------------------------------------------------------
module gsmc_quarter
  import gsmc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int STAGE     = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_ok,
  input  logic [level_k_w(MAX_LEVEL)-1:0] in_k,
  input  point_t                         in_pt,
  input  mesh_digits_t                   in_dg,
  input  logic [qd_int_w(MAX_LEVEL)-1:0] in_qd,
  input  logic [rlat_w(FRAC_BITS)-1:0]   in_rlat,
  input  logic [rlon_w(FRAC_BITS)-1:0]   in_rlon,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  output logic [level_k_w(MAX_LEVEL)-1:0] out_k,
  output point_t                         out_pt,
  output mesh_digits_t                   out_dg,
  output logic [qd_int_w(MAX_LEVEL)-1:0] out_qd,
  output logic [rlat_w(FRAC_BITS)-1:0]   out_rlat,
  output logic [rlon_w(FRAC_BITS)-1:0]   out_rlon
);

  localparam int QW   = qd_int_w(MAX_LEVEL);
  localparam int RL_W = rlat_w(FRAC_BITS);
  localparam int RN_W = rlon_w(FRAC_BITS);
  localparam logic [RL_W:0] LAT_STEP = (RL_W + 1)'(LAT_CELL_SEC * (2 ** FRAC_BITS));
  localparam logic [RN_W:0] LON_STEP = (RN_W + 1)'(LON_CELL_SEC * (2 ** FRAC_BITS));

  logic [QW-1:0]   qd;
  logic [RL_W-1:0] rl;
  logic [RN_W-1:0] rn;

  // Levels below or at the requested one take a step; the rest pass through
  always_comb begin
    logic [RL_W:0] dl;
    logic [RN_W:0] dn;
    int            j;
    qd = in_qd;
    rl = in_rlat;
    rn = in_rlon;
    for (int i = 0; i < QUARTER_PER_STAGE; i++) begin
      j  = STAGE * QUARTER_PER_STAGE + i;
      dl = {rl, 1'b0};
      dn = {rn, 1'b0};
      if (j < int'(in_k)) begin
        if (dl >= LAT_STEP) begin
          qd[2*j+1] = 1'b1;
          dl        = dl - LAT_STEP;
        end
        if (dn >= LON_STEP) begin
          qd[2*j]   = 1'b1;
          dn        = dn - LON_STEP;
        end
        rl = dl[RL_W-1:0];
        rn = dn[RN_W-1:0];
      end
    end
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_ok   <= in_ok;
      out_k    <= in_k;
      out_pt   <= in_pt;
      out_dg   <= in_dg;
      out_qd   <= qd;
      out_rlat <= rl;
      out_rlon <= rn;
    end
  end

endmodule

/* hdl/gsmc_corner.sv */
// ----------------------------------------------------------------------------
// gsmc_corner : cell corner and result register
// Scales the final remainder back to input units, rounding the corner down,
// and holds the result; an invalid point gives all-zero fields.
// ----------------------------------------------------------------------------
module gsmc_corner
  import gsmc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_ok,
  input  logic [level_k_w(MAX_LEVEL)-1:0] in_k,
  input  point_t                         in_pt,
  input  mesh_digits_t                   in_dg,
  input  logic [qd_int_w(MAX_LEVEL)-1:0] in_qd,
  input  logic [rlat_w(FRAC_BITS)-1:0]   in_rlat,
  input  logic [rlon_w(FRAC_BITS)-1:0]   in_rlon,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_code_valid,
  output mesh_digits_t                   out_dg,
  output logic [QD_W-1:0]                out_qd,
  output point_t                         out_corner
);

  localparam int RL_W  = rlat_w(FRAC_BITS);
  localparam int RN_W  = rlon_w(FRAC_BITS);
  localparam int NQ    = MAX_LEVEL - MIN_LEVEL;
  localparam int SUM_LW = ((RL_W > NQ) ? RL_W : NQ) + 1;
  localparam int SUM_NW = ((RN_W > NQ) ? RN_W : NQ) + 1;

  logic [SUM_LW-1:0] sum_lat;
  logic [SUM_NW-1:0] sum_lon;
  point_t            corner;

  // Corner = point minus the remainder scaled down by 2^k, rounded up
  always_comb begin
    sum_lat    = SUM_LW'(in_rlat) + ((SUM_LW'(1) << in_k) - SUM_LW'(1));
    sum_lon    = SUM_NW'(in_rlon) + ((SUM_NW'(1) << in_k) - SUM_NW'(1));
    corner.lat = in_pt.lat - LAT_W'(sum_lat >> in_k);
    corner.lon = in_pt.lon - LON_W'(sum_lon >> in_k);
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_code_valid <= in_ok;
      out_dg         <= in_ok ? in_dg : '0;
      out_qd         <= in_ok ? in_qd[QD_W-1:0] : '0;
      out_corner     <= in_ok ? corner : '0;
    end
  end

endmodule

/* hdl/grid_square_mesh_code_top.sv */
// ----------------------------------------------------------------------------
// grid_square_mesh_code_top : grid square mesh code encoder
// Codes one fixed-point latitude/longitude pair into mesh digits at the
// configured level, with the lower-left corner of the cell.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  point    in         point_valid/point_stall   latitude, longitude
//  mesh     out        mesh_valid/mesh_stall     code_valid .. corner_longitude
//  config   in         cfg_wr_en                 cfg_wr_data (mesh_level)
//
//  One point per cycle sustained while mesh_stall stays low. Points pass
//  the input register, division, digit, quarter digit and result stages.
//  Reset is synchronous: it empties the pipeline and sets the level to 3.
//  Every stage holds while the one after it is full and stalled; a stage
//  with a free slot keeps taking transfers, so bubbles close up.
// ----------------------------------------------------------------------------
module grid_square_mesh_code_top
  import gsmc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LEVEL_W-1:0] cfg_wr_data,
  input  logic               point_valid,
  output logic               point_stall,
  input  logic [LAT_W-1:0]   latitude,
  input  logic [LON_W-1:0]   longitude,
  output logic               mesh_valid,
  input  logic               mesh_stall,
  output logic               code_valid,
  output logic [6:0]         first_lat_code,
  output logic [6:0]         first_lon_code,
  output logic [2:0]         second_lat_digit,
  output logic [2:0]         second_lon_digit,
  output logic [3:0]         third_lat_digit,
  output logic [3:0]         third_lon_digit,
  output logic [QD_W-1:0]    quarter_digits,
  output logic [LAT_W-1:0]   corner_latitude,
  output logic [LON_W-1:0]   corner_longitude
);

  localparam int K_W  = level_k_w(MAX_LEVEL);
  localparam int QW   = qd_int_w(MAX_LEVEL);
  localparam int RL_W = rlat_w(FRAC_BITS);
  localparam int RN_W = rlon_w(FRAC_BITS);
  localparam int NQS  = quarter_stages(MAX_LEVEL);

  // Level register
  logic [LEVEL_W-1:0] mesh_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_level <= LEVEL_RESET;
    end else if (cfg_wr_en) begin
      mesh_level <= cfg_wr_data;
    end
  end

  point_t in_pt;
  assign in_pt.lat = latitude;
  assign in_pt.lon = longitude;

  // Front stages
  logic           f_valid, f_stall, f_ok;
  logic [K_W-1:0] f_k;
  point_t         f_pt;
  quot_t          f_q;

  gsmc_front #(
    .MAX_LEVEL (MAX_LEVEL),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point_valid),
    .in_stall  (point_stall),
    .level     (mesh_level),
    .in_pt     (in_pt),
    .out_valid (f_valid),
    .out_stall (f_stall),
    .out_ok    (f_ok),
    .out_k     (f_k),
    .out_pt    (f_pt),
    .out_q     (f_q)
  );

  // Quarter chain; slot 0 is the digit stage output
  logic            q_valid [NQS+1];
  logic            q_stall [NQS+1];
  logic            q_ok    [NQS+1];
  logic [K_W-1:0]  q_k     [NQS+1];
  point_t          q_pt    [NQS+1];
  mesh_digits_t    q_dg    [NQS+1];
  logic [QW-1:0]   q_qd    [NQS+1];
  logic [RL_W-1:0] q_rlat  [NQS+1];
  logic [RN_W-1:0] q_rlon  [NQS+1];

  gsmc_digits #(
    .MAX_LEVEL (MAX_LEVEL),
    .FRAC_BITS (FRAC_BITS)
  ) u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_ok     (f_ok),
    .in_k      (f_k),
    .in_pt     (f_pt),
    .in_q      (f_q),
    .out_valid (q_valid[0]),
    .out_stall (q_stall[0]),
    .out_ok    (q_ok[0]),
    .out_k     (q_k[0]),
    .out_pt    (q_pt[0]),
    .out_dg    (q_dg[0]),
    .out_rlat  (q_rlat[0]),
    .out_rlon  (q_rlon[0])
  );

  assign q_qd[0] = '0;

  for (genvar s = 0; s < NQS; s++) begin : g_quarter
    gsmc_quarter #(
      .MAX_LEVEL (MAX_LEVEL),
      .FRAC_BITS (FRAC_BITS),
      .STAGE     (s)
    ) u_quarter (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (q_valid[s]),
      .in_stall  (q_stall[s]),
      .in_ok     (q_ok[s]),
      .in_k      (q_k[s]),
      .in_pt     (q_pt[s]),
      .in_dg     (q_dg[s]),
      .in_qd     (q_qd[s]),
      .in_rlat   (q_rlat[s]),
      .in_rlon   (q_rlon[s]),
      .out_valid (q_valid[s+1]),
      .out_stall (q_stall[s+1]),
      .out_ok    (q_ok[s+1]),
      .out_k     (q_k[s+1]),
      .out_pt    (q_pt[s+1]),
      .out_dg    (q_dg[s+1]),
      .out_qd    (q_qd[s+1]),
      .out_rlat  (q_rlat[s+1]),
      .out_rlon  (q_rlon[s+1])
    );
  end

  // Result register
  mesh_digits_t out_dg;
  point_t       out_corner;

  gsmc_corner #(
    .MAX_LEVEL (MAX_LEVEL),
    .FRAC_BITS (FRAC_BITS)
  ) u_corner (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (q_valid[NQS]),
    .in_stall       (q_stall[NQS]),
    .in_ok          (q_ok[NQS]),
    .in_k           (q_k[NQS]),
    .in_pt          (q_pt[NQS]),
    .in_dg          (q_dg[NQS]),
    .in_qd          (q_qd[NQS]),
    .in_rlat        (q_rlat[NQS]),
    .in_rlon        (q_rlon[NQS]),
    .out_valid      (mesh_valid),
    .out_stall      (mesh_stall),
    .out_code_valid (code_valid),
    .out_dg         (out_dg),
    .out_qd         (quarter_digits),
    .out_corner     (out_corner)
  );

  assign first_lat_code   = out_dg.first_lat;
  assign first_lon_code   = out_dg.first_lon;
  assign second_lat_digit = out_dg.second_lat;
  assign second_lon_digit = out_dg.second_lon;
  assign third_lat_digit  = out_dg.third_lat;
  assign third_lon_digit  = out_dg.third_lon;
  assign corner_latitude  = out_corner.lat;
  assign corner_longitude = out_corner.lon;

endmodule

/* hdl/gsmc_chk.sv */
// ----------------------------------------------------------------------------
// gsmc_chk : port checker for the mesh code encoder
// Watches the top level ports for result hold under stall, zeroed invalid
// results, digit ranges and input stall cause.
// ----------------------------------------------------------------------------
module gsmc_chk
  import gsmc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             point_valid,
  input logic             point_stall,
  input logic             mesh_valid,
  input logic             mesh_stall,
  input logic             code_valid,
  input logic [6:0]       first_lat_code,
  input logic [6:0]       first_lon_code,
  input logic [2:0]       second_lat_digit,
  input logic [2:0]       second_lon_digit,
  input logic [3:0]       third_lat_digit,
  input logic [3:0]       third_lon_digit,
  input logic [QD_W-1:0]  quarter_digits,
  input logic [LAT_W-1:0] corner_latitude,
  input logic [LON_W-1:0] corner_longitude
);

  // Stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    mesh_valid && mesh_stall |=> mesh_valid)
    else $error("result dropped while stalled");

  // Stalled result does not change
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    mesh_valid && mesh_stall |=> $stable(code_valid) && $stable(quarter_digits) &&
      $stable(corner_latitude) && $stable(corner_longitude))
    else $error("result changed while stalled");

  // Input stalls only when a result waits at a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    point_stall |-> mesh_valid && mesh_stall)
    else $error("input stalled with room in the pipeline");

  // Invalid result carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    mesh_valid && !code_valid |-> first_lat_code == 7'd0 && first_lon_code == 7'd0 &&
      second_lat_digit == 3'd0 && second_lon_digit == 3'd0 &&
      third_lat_digit == 4'd0 && third_lon_digit == 4'd0 &&
      quarter_digits == '0 && corner_latitude == '0 && corner_longitude == '0)
    else $error("invalid result with nonzero fields");

  // Valid result digits lie in their ranges
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    mesh_valid && code_valid |-> first_lat_code >= 7'd10 && first_lat_code <= 7'd99 &&
      first_lon_code >= 7'd10 && first_lon_code <= 7'd79 &&
      third_lat_digit <= 4'd9 && third_lon_digit <= 4'd9)
    else $error("mesh digit out of range");

endmodule

bind grid_square_mesh_code_top gsmc_chk u_gsmc_chk (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : grid square mesh code encoder
// Drives points into the encoder with bursty traffic and a stalling receiver,
// and checks every mesh transfer against an expected code, given or from a bit-exact integer predictor.
// A short directed table covers area edges, invalid levels and saturation;
// random phases then sweep the mesh level with mostly in-area points.
// ----------------------------------------------------------------------------
module testbench;
  import gsmc_pkg::*;

  localparam longint unsigned UNIT = 64'd1 << FRAC_BITS_DEF;
  localparam int TOP_LEVEL = MAX_LEVEL_DEF;

  // Coded area in input units
  localparam logic [LAT_W-1:0] AREA_LAT_LO = 29'd24576000;
  localparam logic [LAT_W-1:0] AREA_LAT_HI = 29'd245759999;
  localparam logic [LON_W-1:0] AREA_LON_LO = 30'd405504000;
  localparam logic [LON_W-1:0] AREA_LON_HI = 30'd663551999;
  localparam int LAT_CELL = 30 * 1024;
  localparam int LON_CELL = 45 * 1024;

  // A point well inside the area
  localparam logic [LAT_W-1:0] MID_LAT = 29'd131527000;
  localparam logic [LON_W-1:0] MID_LON = 30'd514806000;

  localparam int PHASE_ITEMS = 150;
  localparam int N_PHASES    = 9;

  typedef struct packed {
    logic              code_valid;
    logic [6:0]        first_lat_code;
    logic [6:0]        first_lon_code;
    logic [2:0]        second_lat_digit;
    logic [2:0]        second_lon_digit;
    logic [3:0]        third_lat_digit;
    logic [3:0]        third_lon_digit;
    logic [QD_W-1:0]   quarter_digits;
    logic [LAT_W-1:0]  corner_latitude;
    logic [LON_W-1:0]  corner_longitude;
  } mesh_code_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LAT_W-1:0]   lat;
    logic [LON_W-1:0]   lon;
    logic               typed;
    mesh_code_t         want;
  } row_t;

  localparam logic PREDICT = 1'b0;
  localparam logic GIVEN   = 1'b1;

  localparam mesh_code_t NO_CODE = '0;
  // Lower-left corner of the first cell in the area: every digit zero
  localparam mesh_code_t CORNER_CODE = '{1'b1, 7'd10, 7'd10, 3'd0, 3'd0, 4'd0, 4'd0,
                                         14'd0, 29'd24576000, 30'd405504000};

  // Directed points
  localparam row_t DIR_ROWS [22] = '{
    '{4'd3,  29'd0,         30'd0,          GIVEN,   NO_CODE},
    '{4'd3,  29'd331776000, 30'd663552000,  GIVEN,   NO_CODE},
    '{4'd3,  29'h1FFFFFFF,  30'h3FFFFFFF,   GIVEN,   NO_CODE},
    '{4'd3,  AREA_LAT_LO,   AREA_LON_LO,    GIVEN,   CORNER_CODE},
    '{4'd3,  AREA_LAT_HI,   AREA_LON_HI,    PREDICT, NO_CODE},
    '{4'd3,  29'd245760000, MID_LON,        GIVEN,   NO_CODE},
    '{4'd3,  29'd24575999,  MID_LON,        GIVEN,   NO_CODE},
    '{4'd3,  MID_LAT,       30'd405503999,  GIVEN,   NO_CODE},
    '{4'd3,  MID_LAT,       30'd663552000,  GIVEN,   NO_CODE},
    '{4'd3,  MID_LAT,       MID_LON,        PREDICT, NO_CODE},
    '{4'd0,  MID_LAT,       MID_LON,        GIVEN,   NO_CODE},
    '{4'd1,  MID_LAT,       MID_LON,        GIVEN,   NO_CODE},
    '{4'd2,  MID_LAT,       MID_LON,        GIVEN,   NO_CODE},
    '{4'd4,  MID_LAT,       MID_LON,        PREDICT, NO_CODE},
    '{4'd4,  29'd24606719,  30'd405550079,  PREDICT, NO_CODE},
    '{4'd10, AREA_LAT_LO,   AREA_LON_LO,    GIVEN,   CORNER_CODE},
    '{4'd10, AREA_LAT_HI,   AREA_LON_HI,    PREDICT, NO_CODE},
    '{4'd10, MID_LAT,       MID_LON,        PREDICT, NO_CODE},
    '{4'd15, MID_LAT,       MID_LON,        PREDICT, NO_CODE},
    '{4'd11, AREA_LAT_HI,   AREA_LON_HI,    PREDICT, NO_CODE},
    '{4'd7,  MID_LAT,       MID_LON,        PREDICT, NO_CODE},
    '{4'd10, 29'd0,         30'd0,          GIVEN,   NO_CODE}
  };

  localparam logic [LEVEL_W-1:0] PHASE_LEVELS [8] = '{
    4'd10, 4'd3, 4'd4, 4'd15, 4'd6, 4'd1, 4'd8, 4'd10
  };

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [LEVEL_W-1:0] cfg_wr_data;
  logic               point_valid;
  logic               point_stall;
  logic [LAT_W-1:0]   latitude;
  logic [LON_W-1:0]   longitude;
  logic               mesh_valid;
  logic               mesh_stall;
  logic               code_valid;
  logic [6:0]         first_lat_code;
  logic [6:0]         first_lon_code;
  logic [2:0]         second_lat_digit;
  logic [2:0]         second_lon_digit;
  logic [3:0]         third_lat_digit;
  logic [3:0]         third_lon_digit;
  logic [QD_W-1:0]    quarter_digits;
  logic [LAT_W-1:0]   corner_latitude;
  logic [LON_W-1:0]   corner_longitude;

  mesh_code_t         pending_codes [$];
  logic [LEVEL_W-1:0] level_now;
  int                 mismatch_count;
  int                 results_seen;

  grid_square_mesh_code_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .point_valid      (point_valid),
    .point_stall      (point_stall),
    .latitude         (latitude),
    .longitude        (longitude),
    .mesh_valid       (mesh_valid),
    .mesh_stall       (mesh_stall),
    .code_valid       (code_valid),
    .first_lat_code   (first_lat_code),
    .first_lon_code   (first_lon_code),
    .second_lat_digit (second_lat_digit),
    .second_lon_digit (second_lon_digit),
    .third_lat_digit  (third_lat_digit),
    .third_lon_digit  (third_lon_digit),
    .quarter_digits   (quarter_digits),
    .corner_latitude  (corner_latitude),
    .corner_longitude (corner_longitude)
  );

  // Mesh code of one point at the given level register value
  function automatic mesh_code_t encode_mesh(input logic [LAT_W-1:0] lat,
                                             input logic [LON_W-1:0] lon,
                                             input logic [LEVEL_W-1:0] lvl_reg);
    mesh_code_t r;
    longint unsigned c12, deg, rlat, rlon, d5, d6, d7, d8, qd, k, rnd, blat, blon;
    int lvl, i;
    r = '0;
    lvl = int'(lvl_reg);
    if (lvl > TOP_LEVEL) lvl = TOP_LEVEL;
    if (lvl < 3) return r;
    c12 = lat / (2400 * UNIT);
    deg = lon / (3600 * UNIT);
    if (c12 < 10 || c12 > 99 || deg < 110 || deg > 179) return r;
    rlat = lat - c12 * 2400 * UNIT;
    rlon = lon - deg * 3600 * UNIT;
    d5 = rlat / (300 * UNIT);
    d6 = rlon / (450 * UNIT);
    rlat -= d5 * 300 * UNIT;
    rlon -= d6 * 450 * UNIT;
    d7 = rlat / (30 * UNIT);
    d8 = rlon / (45 * UNIT);
    rlat -= d7 * 30 * UNIT;
    rlon -= d8 * 45 * UNIT;
    // each quarter level doubles the remainder against the third-level cell
    qd = 0;
    for (i = 4; i <= lvl; i++) begin
      rlat = rlat << 1;
      rlon = rlon << 1;
      blat = 0;
      blon = 0;
      if (rlat >= 30 * UNIT) begin
        blat = 1;
        rlat -= 30 * UNIT;
      end
      if (rlon >= 45 * UNIT) begin
        blon = 1;
        rlon -= 45 * UNIT;
      end
      qd |= ((blat << 1) | blon) << (2 * (i - 4));
    end
    k = lvl - 3;
    rnd = (64'd1 << k) - 1;
    r.code_valid       = 1'b1;
    r.first_lat_code   = 7'(c12);
    r.first_lon_code   = 7'(deg - 100);
    r.second_lat_digit = 3'(d5);
    r.second_lon_digit = 3'(d6);
    r.third_lat_digit  = 4'(d7);
    r.third_lon_digit  = 4'(d8);
    r.quarter_digits   = QD_W'(qd);
    r.corner_latitude  = LAT_W'(lat - ((rlat + rnd) >> k));
    r.corner_longitude = LON_W'(lon - ((rlon + rnd) >> k));
    return r;
  endfunction

  // Hold the point channel empty for a stretch set by n
  task automatic idle_point(input int n);
    repeat (n) begin
      @(negedge clk);
      point_valid <= 1'b0;
    end
  endtask

  // Offer one point and log its expected code once the transfer happens
  task automatic send_point(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
                            input mesh_code_t want);
    @(negedge clk);
    point_valid <= 1'b1;
    latitude    <= lat;
    longitude   <= lon;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    pending_codes.insert(pending_codes.size(), want);
  endtask

  // Level writes only with the pipeline drained
  task automatic set_level(input logic [LEVEL_W-1:0] lvl);
    idle_point(1);
    while (pending_codes.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    level_now = lvl;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: stall pattern in stretches, plus one long hold-off
  initial begin
    int  mode;
    int  stretch;
    bit  held;
    mesh_stall = 1'b0;
    held = 1'b0;
    forever begin
      if (!held && results_seen >= 500) begin
        held = 1'b1;
        repeat (200) begin
          @(negedge clk);
          mesh_stall <= 1'b1;
        end
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 80);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0: begin
            mesh_stall <= 1'b0;
          end
          1: begin
            mesh_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            mesh_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            mesh_stall <= ~mesh_stall;
          end
        endcase
      end
    end
  end

  // Check each mesh transfer against the oldest expected code
  always @(posedge clk) begin
    mesh_code_t got;
    mesh_code_t want;
    if (!rst && mesh_valid && !mesh_stall) begin
      got = '{code_valid, first_lat_code, first_lon_code, second_lat_digit,
              second_lon_digit, third_lat_digit, third_lon_digit, quarter_digits,
              corner_latitude, corner_longitude};
      results_seen++;
      if (pending_codes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected mesh transfer: valid %0d codes %0d %0d corner %0d %0d",
                   got.code_valid, got.first_lat_code, got.first_lon_code,
                   got.corner_latitude, got.corner_longitude);
        mismatch_count++;
      end else begin
        want = pending_codes.pop_front();
        // packed compare covers every field
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("mesh mismatch at result %0d", results_seen);
            $display("  exp: v %0d c %0d/%0d d2 %0d/%0d d3 %0d/%0d q %h corner %0d/%0d",
                     want.code_valid, want.first_lat_code, want.first_lon_code,
                     want.second_lat_digit, want.second_lon_digit,
                     want.third_lat_digit, want.third_lon_digit, want.quarter_digits,
                     want.corner_latitude, want.corner_longitude);
            $display("  got: v %0d c %0d/%0d d2 %0d/%0d d3 %0d/%0d q %h corner %0d/%0d",
                     got.code_valid, got.first_lat_code, got.first_lon_code,
                     got.second_lat_digit, got.second_lon_digit,
                     got.third_lat_digit, got.third_lon_digit, got.quarter_digits,
                     got.corner_latitude, got.corner_longitude);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int n;
    int ph;
    int burst_left;
    int gap;
    logic [LEVEL_W-1:0] lvl;
    logic [LAT_W-1:0]   la;
    logic [LON_W-1:0]   lo;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    point_valid    = 1'b0;
    latitude       = '0;
    longitude      = '0;
    level_now      = LEVEL_RESET;
    mismatch_count = 0;
    results_seen   = 0;
    burst_left     = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (n = 0; n < 22; n++) begin
      if (DIR_ROWS[n].level != level_now) set_level(DIR_ROWS[n].level);
      idle_point($urandom_range(0, 2));
      send_point(DIR_ROWS[n].lat, DIR_ROWS[n].lon,
                 DIR_ROWS[n].typed ? DIR_ROWS[n].want
                                   : encode_mesh(DIR_ROWS[n].lat, DIR_ROWS[n].lon, level_now));
    end

    // Random phases, one level each
    for (ph = 0; ph < N_PHASES; ph++) begin
      lvl = (ph < 8) ? PHASE_LEVELS[ph] : LEVEL_W'($urandom_range(0, 15));
      set_level(lvl);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          idle_point(gap);
        end
        burst_left--;
        case ($urandom_range(0, 9))
          0: begin
            // noise over the full port width
            la = LAT_W'($urandom);
            lo = LON_W'($urandom);
          end
          1: begin
            // snapped to a third-level cell edge
            la = LAT_W'($urandom_range(AREA_LAT_HI, AREA_LAT_LO));
            lo = LON_W'($urandom_range(AREA_LON_HI, AREA_LON_LO));
            la = LAT_W'(la - la % LAT_CELL + ($urandom_range(0, 1) ? LAT_CELL - 1 : 0));
            lo = LON_W'(lo - lo % LON_CELL + ($urandom_range(0, 1) ? LON_CELL - 1 : 0));
          end
          2: begin
            // straddling the area border
            la = LAT_W'($urandom_range(AREA_LAT_HI + 3000000, AREA_LAT_LO - 3000000));
            lo = LON_W'($urandom_range(AREA_LON_HI + 4000000, AREA_LON_LO - 4000000));
          end
          default: begin
            la = LAT_W'($urandom_range(AREA_LAT_HI, AREA_LAT_LO));
            lo = LON_W'($urandom_range(AREA_LON_HI, AREA_LON_LO));
          end
        endcase
        send_point(la, lo, encode_mesh(la, lo, level_now));
      end
    end

    // Drain and settle
    idle_point(1);
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (mismatch_count == 0 && pending_codes.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hdl/gsmc_pkg.sv
hdl/gsmc_front.sv
hdl/gsmc_digits.sv
hdl/gsmc_quarter.sv
hdl/gsmc_corner.sv
hdl/grid_square_mesh_code_top.sv
hdl/gsmc_chk.sv
bench/testbench.sv
